### hdl/fdsu_pkg.sv
// fdsu_pkg: shared sizes, command codes and error codes for the dual stack unit
// depends on nothing; used by forth_dual_stack_unit
`timescale 1ns / 1ps

package fdsu_pkg;

    // stack geometry
    localparam int DATA_DEPTH   = 16;
    localparam int RETURN_DEPTH = 16;
    localparam int CELL_BITS    = 16;

    // item field widths
    localparam int CMD_W   = 3;
    localparam int VALUE_W = 16;
    localparam int INDEX_W = 4;
    localparam int ERR_W   = 3;
    localparam int DEPTH_W = 5;

    // derived widths
    localparam int D_CNT_W  = $clog2(DATA_DEPTH + 1);
    localparam int R_CNT_W  = $clog2(RETURN_DEPTH + 1);
    localparam int D_ADDR_W = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
    localparam int R_ADDR_W = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
    localparam int PICK_W   = ((D_CNT_W > INDEX_W) ? D_CNT_W : INDEX_W) + 1;

    // commands
    localparam logic [CMD_W-1:0] CMD_PUSH_DATA   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP_DATA    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ_TOP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PICK        = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PUSH_RETURN = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POP_RETURN  = 3'd5;

    // error codes
    localparam logic [ERR_W-1:0] ERR_OK       = 3'd0;
    localparam logic [ERR_W-1:0] ERR_D_OVER   = 3'd1;
    localparam logic [ERR_W-1:0] ERR_D_UNDER  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_R_OVER   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_R_UNDER  = 3'd4;
    localparam logic [ERR_W-1:0] ERR_PICK     = 3'd5;

    typedef logic [CELL_BITS-1:0] cell_t;

endpackage

### hdl/forth_dual_stack_unit.sv
// forth_dual_stack_unit: data stack and return stack with push, pop, top and pick
// depends on fdsu_pkg (sizes, command and error codes)
`timescale 1ns / 1ps

// Usage
//   input channel: in_valid / in_stall carrying cmd, value, index
//   output channel: out_valid / out_stall carrying read_value, error,
//   data_depth, return_depth; exactly one result item per input item, in order
//   an item moves when valid is high and stall is low at a rising clk edge
// Pipeline and throughput
//   an accepted item lands in the input register; when the result register
//   is empty or being taken, the item executes against both stacks and loads
//   the result register, which then offers the result
//   one item per cycle sustained while out_stall stays low: each command is one
//   count update plus one indexed read or write of a 16-entry register file
// Stall behavior
//   when out_stall holds a waiting result, the input register stops and
//   in_stall rises as soon as it holds an item; nothing is lost or repeated
// Reset
//   rst_n low clears both depths and all valid flags at once; stack cells
//   are not cleared, and only ever read below the current depth

module forth_dual_stack_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fdsu_pkg::CMD_W-1:0]    cmd,
    input  logic [fdsu_pkg::VALUE_W-1:0]  value,
    input  logic [fdsu_pkg::INDEX_W-1:0]  index,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fdsu_pkg::VALUE_W-1:0]  read_value,
    output logic [fdsu_pkg::ERR_W-1:0]    error,
    output logic [fdsu_pkg::DEPTH_W-1:0]  data_depth,
    output logic [fdsu_pkg::DEPTH_W-1:0]  return_depth
);

    // input register
    logic                           in_valid_reg;
    logic [fdsu_pkg::CMD_W-1:0]     cmd_reg;
    logic [fdsu_pkg::VALUE_W-1:0]   value_reg;
    logic [fdsu_pkg::INDEX_W-1:0]   index_reg;

    // stack state
    fdsu_pkg::cell_t                data_store_reg [fdsu_pkg::DATA_DEPTH];
    fdsu_pkg::cell_t                return_store_reg [fdsu_pkg::RETURN_DEPTH];
    logic [fdsu_pkg::D_CNT_W-1:0]   data_count_reg;
    logic [fdsu_pkg::D_CNT_W-1:0]   data_count_next;
    logic [fdsu_pkg::R_CNT_W-1:0]   return_count_reg;
    logic [fdsu_pkg::R_CNT_W-1:0]   return_count_next;

    // result register
    logic                           out_valid_reg;
    logic [fdsu_pkg::VALUE_W-1:0]   read_value_reg;
    logic [fdsu_pkg::VALUE_W-1:0]   read_value_next;
    logic [fdsu_pkg::ERR_W-1:0]     error_reg;
    logic [fdsu_pkg::ERR_W-1:0]     error_next;

    // execute-stage signals
    logic                           advance;
    logic                           exec;
    logic                           d_full;
    logic                           d_empty;
    logic                           r_full;
    logic                           r_empty;
    logic                           d_write;
    logic                           r_write;
    logic [fdsu_pkg::INDEX_W-1:0]   rd_index;
    logic [fdsu_pkg::PICK_W-1:0]    d_pos;
    logic                           pick_ok;
    logic [fdsu_pkg::D_ADDR_W-1:0]  d_rd_addr;
    logic [fdsu_pkg::D_ADDR_W-1:0]  d_wr_addr;
    logic [fdsu_pkg::R_CNT_W-1:0]   r_top;
    logic [fdsu_pkg::R_ADDR_W-1:0]  r_rd_addr;
    logic [fdsu_pkg::R_ADDR_W-1:0]  r_wr_addr;
    logic [63:0]                    value_wide;
    fdsu_pkg::cell_t                push_cell;
    logic [63:0]                    d_rd_wide;
    logic [63:0]                    r_rd_wide;
    logic [31:0]                    d_cnt_wide;
    logic [31:0]                    r_cnt_wide;

    // pipeline moves when the result register is empty or being taken
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign exec     = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg   <= cmd;
            value_reg <= value;
            index_reg <= index;
        end
    end

    // status of both stacks
    assign d_full  = (data_count_reg >= fdsu_pkg::D_CNT_W'(fdsu_pkg::DATA_DEPTH));
    assign d_empty = (data_count_reg == '0);
    assign r_full  = (return_count_reg >= fdsu_pkg::R_CNT_W'(fdsu_pkg::RETURN_DEPTH));
    assign r_empty = (return_count_reg == '0);

    // data stack read address: top for pop and read-top, top minus index for pick
    assign rd_index  = (cmd_reg == fdsu_pkg::CMD_PICK) ? index_reg : '0;
    assign d_pos     = fdsu_pkg::PICK_W'(data_count_reg) - fdsu_pkg::PICK_W'(1)
                       - fdsu_pkg::PICK_W'(rd_index);
    assign pick_ok   = (fdsu_pkg::PICK_W'(index_reg) < fdsu_pkg::PICK_W'(data_count_reg));
    assign d_rd_addr = d_pos[fdsu_pkg::D_ADDR_W-1:0];
    assign d_wr_addr = data_count_reg[fdsu_pkg::D_ADDR_W-1:0];

    assign r_top     = return_count_reg - fdsu_pkg::R_CNT_W'(1);
    assign r_rd_addr = r_top[fdsu_pkg::R_ADDR_W-1:0];
    assign r_wr_addr = return_count_reg[fdsu_pkg::R_ADDR_W-1:0];

    // cell fitting: pushed value is masked or widened to the cell width
    assign value_wide = 64'(value_reg);
    assign push_cell  = value_wide[fdsu_pkg::CELL_BITS-1:0];
    assign d_rd_wide  = 64'(data_store_reg[d_rd_addr]);
    assign r_rd_wide  = 64'(return_store_reg[r_rd_addr]);

    always_comb
    begin
        data_count_next   = data_count_reg;
        return_count_next = return_count_reg;
        read_value_next   = '0;
        error_next        = fdsu_pkg::ERR_OK;
        d_write           = 1'b0;
        r_write           = 1'b0;
        case (cmd_reg)
            fdsu_pkg::CMD_PUSH_DATA:
            begin
                if (d_full)
                begin
                    error_next = fdsu_pkg::ERR_D_OVER;
                end
                else
                begin
                    d_write         = 1'b1;
                    data_count_next = data_count_reg + fdsu_pkg::D_CNT_W'(1);
                end
            end
            fdsu_pkg::CMD_POP_DATA:
            begin
                if (d_empty)
                begin
                    error_next = fdsu_pkg::ERR_D_UNDER;
                end
                else
                begin
                    data_count_next = data_count_reg - fdsu_pkg::D_CNT_W'(1);
                    read_value_next = d_rd_wide[fdsu_pkg::VALUE_W-1:0];
                end
            end
            fdsu_pkg::CMD_READ_TOP:
            begin
                if (d_empty)
                begin
                    error_next = fdsu_pkg::ERR_D_UNDER;
                end
                else
                begin
                    read_value_next = d_rd_wide[fdsu_pkg::VALUE_W-1:0];
                end
            end
            fdsu_pkg::CMD_PICK:
            begin
                if (!pick_ok)
                begin
                    error_next = fdsu_pkg::ERR_PICK;
                end
                else
                begin
                    read_value_next = d_rd_wide[fdsu_pkg::VALUE_W-1:0];
                end
            end
            fdsu_pkg::CMD_PUSH_RETURN:
            begin
                if (r_full)
                begin
                    error_next = fdsu_pkg::ERR_R_OVER;
                end
                else
                begin
                    r_write           = 1'b1;
                    return_count_next = return_count_reg + fdsu_pkg::R_CNT_W'(1);
                end
            end
            fdsu_pkg::CMD_POP_RETURN:
            begin
                if (r_empty)
                begin
                    error_next = fdsu_pkg::ERR_R_UNDER;
                end
                else
                begin
                    return_count_next = return_count_reg - fdsu_pkg::R_CNT_W'(1);
                    read_value_next   = r_rd_wide[fdsu_pkg::VALUE_W-1:0];
                end
            end
            default:
            begin
                // unused command codes leave everything as is
                error_next = fdsu_pkg::ERR_OK;
            end
        endcase
    end

    // stack cells: written only on a successful push
    always_ff @(posedge clk)
    begin
        if (exec && d_write)
        begin
            data_store_reg[d_wr_addr] <= push_cell;
        end
        if (exec && r_write)
        begin
            return_store_reg[r_wr_addr] <= push_cell;
        end
    end

    // depths and result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_count_reg   <= '0;
            return_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (exec)
            begin
                data_count_reg   <= data_count_next;
                return_count_reg <= return_count_next;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // result payload; depths are read straight from the count registers,
    // which change only when a new result is loaded
    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            read_value_reg <= read_value_next;
            error_reg      <= error_next;
        end
    end

    assign d_cnt_wide = 32'(data_count_reg);
    assign r_cnt_wide = 32'(return_count_reg);

    assign out_valid    = out_valid_reg;
    assign read_value   = read_value_reg;
    assign error        = error_reg;
    assign data_depth   = d_cnt_wide[fdsu_pkg::DEPTH_W-1:0];
    assign return_depth = r_cnt_wide[fdsu_pkg::DEPTH_W-1:0];

endmodule

### tb/tb_top.sv
// tb_top: self-checking testbench for forth_dual_stack_unit (data and return stacks)
// depends on fdsu_pkg and forth_dual_stack_unit; reads no files, needs no arguments
`timescale 1ns / 1ps

module tb_top;

    import fdsu_pkg::*;

    // spare command codes that the block must ignore
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    // clock half period and overall run limit, both in ns
    localparam int CLK_HALF     = 4;
    localparam int RUN_LIMIT_NS = 2_000_000;

    // how many mismatches get printed in full
    localparam int REPORT_LIMIT = 10;

    // one result item as the block presents it
    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic [ERR_W-1:0]   error;
        logic [DEPTH_W-1:0] data_depth;
        logic [DEPTH_W-1:0] return_depth;
    } stack_result_t;

    // receiver stall styles
    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } rx_mode_t;

    // clock, reset and all block inputs start at known values
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [CMD_W-1:0]   cmd       = '0;
    logic [VALUE_W-1:0] value     = '0;
    logic [INDEX_W-1:0] index     = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [VALUE_W-1:0] read_value;
    logic [ERR_W-1:0]   error;
    logic [DEPTH_W-1:0] data_depth;
    logic [DEPTH_W-1:0] return_depth;

    // predicted contents of both stacks, updated as each item is accepted
    cell_t model_data [DATA_DEPTH];
    cell_t model_ret  [RETURN_DEPTH];
    int    model_dcount = 0;
    int    model_rcount = 0;

    // results still owed by the block, oldest first
    stack_result_t result_due_q [$];

    // sender pacing
    int burst_left  = 1;
    bit steady_mode = 1'b0;
    bit filling     = 1'b1;

    // receiver hold-off request, picked up by the receiver process
    int hold_request = 0;

    // bookkeeping for the verdict and the summary
    int fail_count    = 0;
    int report_count  = 0;
    int checked_count = 0;
    int cmd_seen [8];
    int err_seen [8];

    forth_dual_stack_unit DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .value        (value),
        .index        (index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_value   (read_value),
        .error        (error),
        .data_depth   (data_depth),
        .return_depth (return_depth)
    );

    // free-running clock
    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("timeout: %0d results still owed, %0d checked", result_due_q.size(),
                 checked_count);
        $display("*** FAILED ***");
        $finish;
    end

    // apply one command to the predicted stacks and return the result it owes
    // a failing command leaves both stacks alone and reads zero
    function automatic stack_result_t apply_stack_cmd(input logic [CMD_W-1:0]   c,
                                                      input logic [VALUE_W-1:0] v,
                                                      input logic [INDEX_W-1:0] ix);
        stack_result_t r;
        r = '0;
        case (c)
            CMD_PUSH_DATA:
            begin
                if (model_dcount >= DATA_DEPTH)
                    r.error = ERR_D_OVER;
                else
                begin
                    model_data[model_dcount] = v;
                    model_dcount++;
                end
            end
            CMD_POP_DATA:
            begin
                if (model_dcount == 0)
                    r.error = ERR_D_UNDER;
                else
                begin
                    model_dcount--;
                    r.read_value = model_data[model_dcount];
                end
            end
            CMD_READ_TOP:
            begin
                if (model_dcount == 0)
                    r.error = ERR_D_UNDER;
                else
                    r.read_value = model_data[model_dcount - 1];
            end
            CMD_PICK:
            begin
                // index counts down from the top; at or past the depth is out of range
                if (int'(ix) >= model_dcount)
                    r.error = ERR_PICK;
                else
                    r.read_value = model_data[model_dcount - 1 - int'(ix)];
            end
            CMD_PUSH_RETURN:
            begin
                if (model_rcount >= RETURN_DEPTH)
                    r.error = ERR_R_OVER;
                else
                begin
                    model_ret[model_rcount] = v;
                    model_rcount++;
                end
            end
            CMD_POP_RETURN:
            begin
                if (model_rcount == 0)
                    r.error = ERR_R_UNDER;
                else
                begin
                    model_rcount--;
                    r.read_value = model_ret[model_rcount];
                end
            end
            default:
            begin
                // spare codes: nothing moves, zero result
            end
        endcase
        r.data_depth   = model_dcount[DEPTH_W-1:0];
        r.return_depth = model_rcount[DEPTH_W-1:0];
        return r;
    endfunction

    // random cell with extra weight on all zeros and all ones
    function automatic logic [VALUE_W-1:0] random_cell();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        return VALUE_W'($urandom_range(0, (1 << VALUE_W) - 1));
    endfunction

    // offer one item, wait for the handshake, record what it should produce
    // valid stays high into the next item unless the burst ends here
    task automatic send_item(input logic [CMD_W-1:0]   c,
                             input logic [VALUE_W-1:0] v,
                             input logic [INDEX_W-1:0] ix);
        stack_result_t r;
        int            gap;
        cmd      <= c;
        value    <= v;
        index    <= ix;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // accepted at this edge
        r = apply_stack_cmd(c, v, ix);
        result_due_q.push_back(r);
        cmd_seen[c]++;
        err_seen[r.error]++;
        if (!steady_mode)
        begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                // idle gap between bursts
                gap = $urandom_range(1, 6);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    // one well-formed command with random content, steered so both stacks
    // swing between empty and full; a small share is spare-code noise
    task automatic send_random_item();
        int                 roll;
        bit                 push;
        logic [CMD_W-1:0]   c;
        logic [INDEX_W-1:0] ix;
        // turn the trend around near the limits, now and then at random
        if (model_dcount == DATA_DEPTH && $urandom_range(0, 2) == 0)
            filling = 1'b0;
        else if (model_dcount == 0 && $urandom_range(0, 2) == 0)
            filling = 1'b1;
        else if ($urandom_range(0, 39) == 0)
            filling = !filling;
        roll = $urandom_range(0, 99);
        push = ($urandom_range(0, 99) < (filling ? 75 : 25));
        ix   = INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
        if (roll < 3)
            c = roll[0] ? CMD_SPARE_HI : CMD_SPARE_LO;
        else if (roll < 43)
            c = push ? CMD_PUSH_DATA : CMD_POP_DATA;
        else if (roll < 55)
            c = CMD_READ_TOP;
        else if (roll < 70)
        begin
            c = CMD_PICK;
            // mostly a live entry, sometimes any index at all
            if (model_dcount > 0 && $urandom_range(0, 4) != 0)
                ix = INDEX_W'($urandom_range(0, model_dcount - 1));
        end
        else
            c = push ? CMD_PUSH_RETURN : CMD_POP_RETURN;
        send_item(c, random_cell(), ix);
    endtask

    // every pop, read-top and pick command against empty stacks, plus the spare codes
    task automatic test_empty_stacks();
        send_item(CMD_POP_DATA,    random_cell(), '0);
        send_item(CMD_READ_TOP,    random_cell(), '0);
        send_item(CMD_PICK,        random_cell(), '0);
        send_item(CMD_PICK,        random_cell(), '1);
        send_item(CMD_POP_RETURN,  random_cell(), '0);
        send_item(CMD_SPARE_LO,    '1,            '1);
        send_item(CMD_SPARE_HI,    '1,            '1);
    endtask

    // short hand-built sequence: extreme cells, top, pick in and out of range,
    // return stack round trip and underflow on both stacks
    task automatic test_basic_ops();
        send_item(CMD_PUSH_DATA,   '1,       '0);
        send_item(CMD_PUSH_DATA,   '0,       '1);
        send_item(CMD_PUSH_DATA,   16'h5A5A, '0);
        send_item(CMD_READ_TOP,    '0,       '0);
        send_item(CMD_PICK,        '0,       4'd0);
        send_item(CMD_PICK,        '0,       4'd2);
        send_item(CMD_PICK,        '0,       4'd3);
        send_item(CMD_PICK,        '0,       '1);
        send_item(CMD_POP_DATA,    '0,       '0);
        send_item(CMD_PUSH_RETURN, '1,       '0);
        send_item(CMD_PUSH_RETURN, '0,       '0);
        send_item(CMD_POP_RETURN,  '0,       '0);
        send_item(CMD_POP_RETURN,  '0,       '0);
        send_item(CMD_POP_RETURN,  '0,       '0);
        send_item(CMD_POP_DATA,    '0,       '0);
        send_item(CMD_POP_DATA,    '0,       '0);
        send_item(CMD_POP_DATA,    '0,       '0);
    endtask

    // fill both stacks to the brim, push past it, pick the deepest entry,
    // then drain both stacks and pop once more
    task automatic test_stack_limits();
        while (model_dcount < DATA_DEPTH)
            send_item(CMD_PUSH_DATA, random_cell(),
                      INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1)));
        send_item(CMD_PUSH_DATA, random_cell(), '0);
        send_item(CMD_PICK, random_cell(), INDEX_W'(DATA_DEPTH - 1));
        send_item(CMD_READ_TOP, random_cell(), '0);
        while (model_rcount < RETURN_DEPTH)
            send_item(CMD_PUSH_RETURN, random_cell(), '0);
        send_item(CMD_PUSH_RETURN, random_cell(), '0);
        while (model_rcount > 0)
            send_item(CMD_POP_RETURN, random_cell(), '0);
        send_item(CMD_POP_RETURN, random_cell(), '0);
        while (model_dcount > 0)
            send_item(CMD_POP_DATA, random_cell(), '0);
        send_item(CMD_POP_DATA, random_cell(), '0);
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    // back to back, so the block fills and raises in_stall
    task automatic test_backpressure();
        int hold_len [2];
        hold_len[0] = 64;
        hold_len[1] = $urandom_range(12, 30);
        steady_mode = 1'b1;
        foreach (hold_len[k])
        begin
            hold_request = hold_len[k];
            repeat (30) send_random_item();
        end
        steady_mode = 1'b0;
    endtask

    // bulk random traffic; some stretches run with no sender gaps at all
    task automatic test_random_traffic(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 200 == 0)
                steady_mode = ($urandom_range(0, 3) == 0);
            if (i == count / 2)
                hold_request = $urandom_range(20, 80);
            send_random_item();
        end
        steady_mode = 1'b0;
    endtask

    // receiver: a long hold when one is requested, otherwise one of four stall
    // styles, chosen at random
    initial
    begin : receiver
        int       hold_left;
        int       mode_left;
        int       phase_cnt;
        rx_mode_t stall_mode;
        hold_left  = 0;
        mode_left  = 0;
        phase_cnt  = 0;
        stall_mode = RX_FREE;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = rx_mode_t'($urandom_range(0, 3));
                    mode_left  = $urandom_range(30, 200);
                end
                mode_left--;
                case (stall_mode)
                    RX_FREE:  out_stall <= 1'b0;
                    RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:
                    begin
                        // fixed one-in-three stall pattern
                        phase_cnt++;
                        out_stall <= (phase_cnt % 3 == 0);
                    end
                endcase
            end
        end
    end

    // result checker: each accepted result against the oldest owed one
    always @(posedge clk)
    begin : result_check
        stack_result_t due;
        stack_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{read_value, error, data_depth, return_depth};
            if (result_due_q.size() == 0)
            begin
                fail_count++;
                if (report_count < REPORT_LIMIT)
                    $display("%0t: result with nothing owed: rv=%h err=%0d dd=%0d rd=%0d",
                             $realtime, got.read_value, got.error, got.data_depth,
                             got.return_depth);
                report_count++;
            end
            else
            begin
                due = result_due_q.pop_front();
                checked_count++;
                if (got.read_value !== due.read_value || got.error !== due.error ||
                    got.data_depth !== due.data_depth ||
                    got.return_depth !== due.return_depth)
                begin
                    fail_count++;
                    if (report_count < REPORT_LIMIT)
                        $display("%0t: mismatch expected rv=%h err=%0d dd=%0d rd=%0d, got rv=%h err=%0d dd=%0d rd=%0d",
                                 $realtime, due.read_value, due.error, due.data_depth,
                                 due.return_depth, got.read_value, got.error,
                                 got.data_depth, got.return_depth);
                    report_count++;
                end
            end
        end
    end

    // test sequence
    initial
    begin : main_seq
        int waited;
        foreach (cmd_seen[k])
        begin
            cmd_seen[k] = 0;
            err_seen[k] = 0;
        end
        // reset held low from the start, then released at an edge
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        burst_left = $urandom_range(1, 24);

        test_empty_stacks();
        test_basic_ops();
        test_stack_limits();
        test_backpressure();
        test_random_traffic(1300);
        in_valid <= 1'b0;

        // wait for every owed result, then watch on for stray ones
        waited = 0;
        while (result_due_q.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (result_due_q.size() != 0)
        begin
            $display("%0d results never arrived", result_due_q.size());
            fail_count += result_due_q.size();
        end

        $display("run covered %0d items: push %0d, pop %0d, top %0d, pick %0d, rpush %0d, rpop %0d, spare %0d",
                 checked_count, cmd_seen[CMD_PUSH_DATA], cmd_seen[CMD_POP_DATA],
                 cmd_seen[CMD_READ_TOP], cmd_seen[CMD_PICK], cmd_seen[CMD_PUSH_RETURN],
                 cmd_seen[CMD_POP_RETURN], cmd_seen[CMD_SPARE_LO] + cmd_seen[CMD_SPARE_HI]);
        $display("error outcomes: ok %0d, data over %0d, data under %0d, ret over %0d, ret under %0d, pick range %0d; failures %0d",
                 err_seen[ERR_OK], err_seen[ERR_D_OVER], err_seen[ERR_D_UNDER],
                 err_seen[ERR_R_OVER], err_seen[ERR_R_UNDER], err_seen[ERR_PICK], fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
